>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks used by the top-level RTL of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  `ASSERT_AT(label, clk, rst, !(cond), msg)

`endif

>>> hw/rtl/lbcsd_pkg.sv
// ---------------------------------------------------------------------------
// lbcsd_pkg
// Types, constants and parity-matrix helpers for the block code decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbcsd_pkg;

  localparam int CODE_LEN       = 8;
  localparam int MSG_LEN        = 4;
  localparam int PAR_LEN        = CODE_LEN - MSG_LEN;
  localparam int SYNDROME_COUNT = 16;
  localparam int TBL_AW         = $clog2(SYNDROME_COUNT);

  localparam int FUNC_W   = 2;
  localparam int WORD_W   = 8;
  localparam int TIDX_W   = 4;
  localparam int WT_W     = 4;
  localparam int MSG_W    = 4;
  localparam int SYN_W    = 4;
  localparam int PARITY_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DECODE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RSVD   = 2'd3;

  typedef enum logic [1:0] {
    KIND_ENC,
    KIND_DEC,
    KIND_LOAD
  } kind_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] word;
    logic [TIDX_W-1:0] table_index;
    logic [WT_W-1:0]   table_weight;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] codeword;
    logic [MSG_W-1:0]  message;
    logic [SYN_W-1:0]  syndrome_in;
    logic [WT_W-1:0]   weight_left;
  } out_item_t;

  // One pipeline slot: current word, its syndrome and coset weight.
  typedef struct packed {
    logic                vld;
    kind_t               kind;
    logic [CODE_LEN-1:0] cur;
    logic [PAR_LEN-1:0]  s0;
    logic [PAR_LEN-1:0]  s;
    logic [WT_W-1:0]     w;
    logic [TBL_AW-1:0]   tidx;
    logic [WT_W-1:0]     twt;
  } stage_t;

  // Syndrome contribution of a single set bit at position pos.
  function automatic logic [PAR_LEN-1:0] h_col(input logic [PARITY_W-1:0] pb,
                                               input int pos);
    logic [PAR_LEN-1:0] h;
    int idx;
    h = '0;
    if (pos < MSG_LEN) begin
      for (int c = 0; c < PAR_LEN; c++) begin
        idx = pos * PAR_LEN + c;
        if (idx < PARITY_W) h[c] = pb[idx];
      end
    end else begin
      h[pos - MSG_LEN] = 1'b1;
    end
    return h;
  endfunction

  function automatic logic [PAR_LEN-1:0] syndrome(input logic [CODE_LEN-1:0] w,
                                                  input logic [PARITY_W-1:0] pb);
    logic [PAR_LEN-1:0] s;
    s = w[MSG_LEN +: PAR_LEN];
    for (int j = 0; j < MSG_LEN; j++) begin
      if (w[j]) s = s ^ h_col(pb, j);
    end
    return s;
  endfunction

  function automatic logic [CODE_LEN-1:0] encode(input logic [CODE_LEN-1:0] m,
                                                 input logic [PARITY_W-1:0] pb);
    logic [CODE_LEN-1:0] cw;
    logic [PAR_LEN-1:0]  p;
    cw = '0;
    p  = '0;
    cw[MSG_LEN-1:0] = m[MSG_LEN-1:0];
    for (int j = 0; j < MSG_LEN; j++) begin
      if (m[j]) p = p ^ h_col(pb, j);
    end
    cw[MSG_LEN +: PAR_LEN] = p;
    return cw;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lbcsd_front.sv
// ---------------------------------------------------------------------------
// lbcsd_front
// Entry stage: encode or syndrome, first coset weight lookup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbcsd_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                adv,
  input  wire logic                                in_vld,
  input  wire lbcsd_pkg::in_item_t                 in_item,
  input  wire logic [lbcsd_pkg::PARITY_W-1:0]      parity,
  output lbcsd_pkg::stage_t                        res
);

  lbcsd_pkg::stage_t st;
  lbcsd_pkg::stage_t st_next;
  logic [lbcsd_pkg::WT_W-1:0] wt_mem [lbcsd_pkg::SYNDROME_COUNT];
  logic [lbcsd_pkg::WT_W-1:0] rd;
  logic [lbcsd_pkg::CODE_LEN-1:0] word_in;
  logic [lbcsd_pkg::PAR_LEN-1:0]  syn_in;

  always_comb begin
    word_in = in_item.word[lbcsd_pkg::CODE_LEN-1:0];
    syn_in  = lbcsd_pkg::syndrome(word_in, parity);
    st_next      = '0;
    st_next.vld  = in_vld;
    st_next.s    = syn_in;
    st_next.tidx = lbcsd_pkg::TBL_AW'(in_item.table_index);
    st_next.twt  = in_item.table_weight;
    unique case (in_item.func)
      lbcsd_pkg::FUNC_ENCODE: begin
        st_next.kind = lbcsd_pkg::KIND_ENC;
        st_next.cur  = lbcsd_pkg::encode(word_in, parity);
      end
      lbcsd_pkg::FUNC_DECODE: begin
        st_next.kind = lbcsd_pkg::KIND_DEC;
        st_next.cur  = word_in;
        st_next.s0   = syn_in;
      end
      default: begin
        st_next.kind = lbcsd_pkg::KIND_LOAD;
        st_next.cur  = word_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.vld <= 1'b0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  // Local copy of the weight table; loads land here as they pass.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (st_next.vld && st_next.kind == lbcsd_pkg::KIND_LOAD) begin
        wt_mem[st_next.tidx] <= st_next.twt;
      end
      rd <= wt_mem[lbcsd_pkg::TBL_AW'(syn_in)];
    end
  end

  always_comb begin
    res   = st;
    res.w = (st.kind == lbcsd_pkg::KIND_DEC) ? rd : '0;
  end

endmodule

`default_nettype wire

>>> hw/rtl/lbcsd_trial.sv
// ---------------------------------------------------------------------------
// lbcsd_trial
// One flip trial: lookup at the flipped syndrome, keep it if lighter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbcsd_trial #(
  parameter int BIT_POS = 0
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                adv,
  input  wire lbcsd_pkg::stage_t                   prev,
  input  wire logic [lbcsd_pkg::PARITY_W-1:0]      parity,
  output lbcsd_pkg::stage_t                        res
);

  localparam logic [lbcsd_pkg::CODE_LEN-1:0] FLIP =
    {{(lbcsd_pkg::CODE_LEN-1){1'b0}}, 1'b1} << BIT_POS;

  lbcsd_pkg::stage_t st;
  logic [lbcsd_pkg::WT_W-1:0]    wt_mem [lbcsd_pkg::SYNDROME_COUNT];
  logic [lbcsd_pkg::WT_W-1:0]    rd;
  logic [lbcsd_pkg::PAR_LEN-1:0] h;
  logic                          take;

  assign h = lbcsd_pkg::h_col(parity, BIT_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      st.vld <= 1'b0;
    end else if (adv) begin
      st <= prev;
    end
  end

  // Read at the syndrome this trial would produce.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (prev.vld && prev.kind == lbcsd_pkg::KIND_LOAD) begin
        wt_mem[prev.tidx] <= prev.twt;
      end
      rd <= wt_mem[lbcsd_pkg::TBL_AW'(prev.s ^ h)];
    end
  end

  // A zero weight never takes a trial, so the early stop falls out here.
  assign take = st.vld && (st.kind == lbcsd_pkg::KIND_DEC) && (rd < st.w);

  always_comb begin
    res = st;
    if (take) begin
      res.cur = st.cur ^ FLIP;
      res.s   = st.s ^ h;
      res.w   = rd;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/linear_block_code_step_decoder.sv
// ---------------------------------------------------------------------------
// linear_block_code_step_decoder
// Systematic binary block code encoder and step-by-step syndrome decoder.
// ---------------------------------------------------------------------------
// Takes one transaction per clock while the output is not held; results are
// registered through the entry stage, one stage per bit-flip trial and the
// output register. The entry stage and each trial own a private copy of the
// 16-entry coset weight table, so each trial does its single lookup in its own
// stage. Load transactions (func 2) write that table as they travel down the
// pipe, so every copy sees loads and decodes in arrival order; they give no
// result. func 3 is dropped at the input. The table is not cleared at reset:
// fill every entry a decode can reach before decoding. The user must write
// parity_bits on the cfg channel only while the block is idle (not enforced).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module linear_block_code_step_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input transactions
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire lbcsd_pkg::in_item_t               in_item,
  // result transactions
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output lbcsd_pkg::out_item_t                   out_item,
  // parity matrix register
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lbcsd_pkg::PARITY_W-1:0]    cfg_data
);

  localparam int N = lbcsd_pkg::CODE_LEN;

  logic [lbcsd_pkg::PARITY_W-1:0] parity_bits;
  logic                           adv;
  logic                           in_vld;
  lbcsd_pkg::stage_t              chain [0:N];
  logic [N:0]                     vld_vec;

  // Whole pipe moves together; it only freezes when the output is held.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign in_vld    = in_valid && in_ready && (in_item.func != lbcsd_pkg::FUNC_RSVD);

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_bits <= '0;
    end else if (cfg_valid && cfg_ready) begin
      parity_bits <= cfg_data;
    end
  end

  lbcsd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .in_vld (in_vld),
    .in_item(in_item),
    .parity (parity_bits),
    .res    (chain[0])
  );

  // Trial i tests flipping bit i of the current word.
  for (genvar i = 0; i < N; i++) begin : g_trial
    lbcsd_trial #(
      .BIT_POS(i)
    ) u_trial (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .prev  (chain[i]),
      .parity(parity_bits),
      .res   (chain[i+1])
    );
  end

  // Output register; loads retire here silently.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= chain[N].vld && (chain[N].kind != lbcsd_pkg::KIND_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.codeword    <= lbcsd_pkg::WORD_W'(chain[N].cur);
      out_item.message     <= lbcsd_pkg::MSG_W'(chain[N].cur[lbcsd_pkg::MSG_LEN-1:0]);
      out_item.syndrome_in <= lbcsd_pkg::SYN_W'(chain[N].s0);
      out_item.weight_left <= chain[N].w;
    end
  end

  always_comb begin
    for (int k = 0; k <= N; k++) begin
      vld_vec[k] = chain[k].vld;
    end
  end

  // A held result freezes the pipe: no transaction appears or vanishes.
  `ASSERT_AT(a_stall_holds_pipe, clk, rst,
             out_valid && !out_ready |=> $stable(vld_vec),
             "pipeline valid bits moved during stall")
  // Reserved func code never enters the pipe.
  `ASSERT_AT(a_rsvd_dropped, clk, rst,
             in_valid && in_ready && in_item.func == lbcsd_pkg::FUNC_RSVD |=> !chain[0].vld,
             "reserved func code entered pipeline")
  // A load leaving the last trial gives no result.
  `ASSERT_AT(a_load_silent, clk, rst,
             adv && chain[N].vld && chain[N].kind == lbcsd_pkg::KIND_LOAD |=> !out_valid,
             "load transaction produced a result")
  `ASSERT_NEVER(a_msg_matches, clk, rst,
                out_valid && out_item.message != out_item.codeword[lbcsd_pkg::MSG_LEN-1:0],
                "message field differs from codeword low bits")

endmodule

`default_nettype wire
